>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a given clock with an active-low reset
`define BLR_ASSERT_CLK(name, clk_sig, rst_sig, prop) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("assertion failed");

// concurrent assertion on clk with rst_n
`define BLR_ASSERT(name, prop) `BLR_ASSERT_CLK(name, clk, rst_n, prop)

`endif

>>> rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// shared types and codes of the line rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blr_pkg;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam int COLOR_BITS = 24;

    typedef enum logic [1:0] {
        OCT_SHALLOW_UP   = 2'd0,
        OCT_STEEP_UP     = 2'd1,
        OCT_SHALLOW_DOWN = 2'd2,
        OCT_STEEP_DOWN   = 2'd3
    } octant_t;

endpackage

>>> rtl/blr_setup.sv
// ----------------------------------------------------------------------------
// blr_setup
// orders the endpoints, picks the octant and forms the initial line state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blr_setup import blr_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output octant_t                      octant,
    output logic signed [COORD_BITS:0]   major_pos,
    output logic signed [COORD_BITS:0]   minor_pos,
    output logic signed [COORD_BITS:0]   major_end,
    output logic signed [COORD_BITS:0]   delta_major,
    output logic signed [COORD_BITS:0]   delta_minor,
    output logic signed [COORD_BITS+3:0] decision
);

    localparam int PW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 4;

    logic                 swap;
    logic signed [PW-1:0] x0;
    logic signed [PW-1:0] y0;
    logic signed [PW-1:0] x1;
    logic signed [PW-1:0] y1;
    logic signed [PW-1:0] dx;
    logic signed [PW-1:0] dy;
    logic signed [PW-1:0] neg_dx;

    assign swap   = x_start > x_end;
    assign x0     = swap ? PW'(x_end)   : PW'(x_start);
    assign y0     = swap ? PW'(y_end)   : PW'(y_start);
    assign x1     = swap ? PW'(x_start) : PW'(x_end);
    assign y1     = swap ? PW'(y_start) : PW'(y_end);
    assign dx     = x1 - x0;
    assign dy     = y1 - y0;
    assign neg_dx = -dx;

    always_comb
    begin
        priority if (dy >= dx)
        begin
            octant      = OCT_STEEP_UP;
            major_pos   = y0;
            major_end   = y1;
            minor_pos   = x0;
            delta_major = dy;
            delta_minor = dx;
        end
        else if (dy <= 0 && dy >= neg_dx)
        begin
            octant      = OCT_SHALLOW_DOWN;
            major_pos   = x0;
            major_end   = x1;
            minor_pos   = -y0;
            delta_major = dx;
            delta_minor = -dy;
        end
        else if (dy < neg_dx)
        begin
            octant      = OCT_STEEP_DOWN;
            major_pos   = -y0;
            major_end   = -y1;
            minor_pos   = x0;
            delta_major = -dy;
            delta_minor = dx;
        end
        else
        begin
            octant      = OCT_SHALLOW_UP;
            major_pos   = x0;
            major_end   = x1;
            minor_pos   = y0;
            delta_major = dx;
            delta_minor = dy;
        end
    end

    assign decision = (DW'(delta_minor) <<< 1) - DW'(delta_major);

endmodule

>>> rtl/blr_step.sv
// ----------------------------------------------------------------------------
// blr_step
// maps the line state to a pixel and advances the decision term
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blr_step import blr_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  octant_t                      octant,
    input  logic signed [COORD_BITS:0]   major_pos,
    input  logic signed [COORD_BITS:0]   minor_pos,
    input  logic signed [COORD_BITS:0]   major_end,
    input  logic signed [COORD_BITS:0]   delta_major,
    input  logic signed [COORD_BITS:0]   delta_minor,
    input  logic signed [COORD_BITS+3:0] decision,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         last,
    output logic signed [COORD_BITS:0]   major_next,
    output logic signed [COORD_BITS:0]   minor_next,
    output logic signed [COORD_BITS+3:0] decision_next
);

    localparam int PW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 4;

    logic signed [PW-1:0] neg_major;
    logic signed [PW-1:0] neg_minor;
    logic                 minor_move;
    logic signed [DW-1:0] twice_major;
    logic signed [DW-1:0] twice_minor;

    assign neg_major = -major_pos;
    assign neg_minor = -minor_pos;

    always_comb
    begin
        unique case (octant)
            OCT_SHALLOW_UP:
            begin
                pixel_x = major_pos[COORD_BITS-1:0];
                pixel_y = minor_pos[COORD_BITS-1:0];
            end
            OCT_STEEP_UP:
            begin
                pixel_x = minor_pos[COORD_BITS-1:0];
                pixel_y = major_pos[COORD_BITS-1:0];
            end
            OCT_SHALLOW_DOWN:
            begin
                pixel_x = major_pos[COORD_BITS-1:0];
                pixel_y = neg_minor[COORD_BITS-1:0];
            end
            OCT_STEEP_DOWN:
            begin
                pixel_x = minor_pos[COORD_BITS-1:0];
                pixel_y = neg_major[COORD_BITS-1:0];
            end
            default:
            begin
                pixel_x = major_pos[COORD_BITS-1:0];
                pixel_y = minor_pos[COORD_BITS-1:0];
            end
        endcase
    end

    assign last        = major_pos == major_end;
    assign minor_move  = !decision[DW-1];
    assign twice_major = DW'(delta_major) <<< 1;
    assign twice_minor = DW'(delta_minor) <<< 1;

    assign major_next    = major_pos + PW'(1);
    assign minor_next    = minor_move ? minor_pos + PW'(1) : minor_pos;
    assign decision_next = decision + twice_minor - (minor_move ? twice_major : DW'(0));

endmodule

>>> rtl/bresenham_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// all-octant integer line rasterizer, one pixel per item
// ----------------------------------------------------------------------------
// usage
//   command channel (cmd_valid / cmd_stall): func = FUNC_START loads two
//   endpoints and a color and gives the first pixel; func = FUNC_STEP gives
//   the next pixel of the active line, or nothing when no line is active.
//   a start item drops any line in progress.
//   pixel channel (pixel_valid / pixel_stall): one pixel with its color;
//   last_pixel marks the final endpoint, after which the line is inactive.
//   an accepted command enters the command register, which feeds setup and
//   step logic; these load the pixel register that drives pixel_valid.
//   throughput is one item per cycle while the pixel is not stalled, set
//   by the single decision update between the command and pixel registers.
//   reset clears both valid flags and the active-line flag.
//   a stalled pixel holds; a command waiting behind it raises cmd_stall,
//   one item deep, so one command is still taken while the pixel waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bresenham_line_rasterizer_unit import blr_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic                         func,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic [COLOR_BITS-1:0]        line_color,
    output logic                         pixel_valid,
    input  logic                         pixel_stall,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [COLOR_BITS-1:0]        pixel_color,
    output logic                         last_pixel
);

    localparam int PW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 4;

    // command register
    logic                         cmd_valid_reg;
    logic                         cmd_valid_next;
    logic                         func_reg;
    logic signed [COORD_BITS-1:0] x_start_reg;
    logic signed [COORD_BITS-1:0] y_start_reg;
    logic signed [COORD_BITS-1:0] x_end_reg;
    logic signed [COORD_BITS-1:0] y_end_reg;
    logic [COLOR_BITS-1:0]        color_reg;

    // line state
    logic                 active_reg;
    logic                 active_next;
    octant_t              octant_reg;
    octant_t              octant_next;
    logic signed [PW-1:0] major_reg;
    logic signed [PW-1:0] major_next;
    logic signed [PW-1:0] minor_reg;
    logic signed [PW-1:0] minor_next;
    logic signed [PW-1:0] end_reg;
    logic signed [PW-1:0] end_next;
    logic signed [PW-1:0] dmaj_reg;
    logic signed [PW-1:0] dmaj_next;
    logic signed [PW-1:0] dmin_reg;
    logic signed [PW-1:0] dmin_next;
    logic signed [DW-1:0] dec_reg;
    logic signed [DW-1:0] dec_next;
    logic [COLOR_BITS-1:0] held_color_reg;
    logic [COLOR_BITS-1:0] held_color_next;

    // pixel register
    logic                         pixel_valid_reg;
    logic                         pixel_valid_next;
    logic signed [COORD_BITS-1:0] pixel_x_reg;
    logic signed [COORD_BITS-1:0] pixel_y_reg;
    logic [COLOR_BITS-1:0]        pixel_color_reg;
    logic                         last_pixel_reg;

    // setup results
    octant_t              su_octant;
    logic signed [PW-1:0] su_major;
    logic signed [PW-1:0] su_minor;
    logic signed [PW-1:0] su_end;
    logic signed [PW-1:0] su_dmaj;
    logic signed [PW-1:0] su_dmin;
    logic signed [DW-1:0] su_dec;

    // step inputs and results
    logic                         is_start;
    octant_t                      cur_octant;
    logic signed [PW-1:0]         cur_major;
    logic signed [PW-1:0]         cur_minor;
    logic signed [PW-1:0]         cur_end;
    logic signed [PW-1:0]         cur_dmaj;
    logic signed [PW-1:0]         cur_dmin;
    logic signed [DW-1:0]         cur_dec;
    logic [COLOR_BITS-1:0]        cur_color;
    logic signed [COORD_BITS-1:0] st_x;
    logic signed [COORD_BITS-1:0] st_y;
    logic                         st_last;
    logic signed [PW-1:0]         st_major;
    logic signed [PW-1:0]         st_minor;
    logic signed [DW-1:0]         st_dec;

    logic cmd_accept;
    logic advance;
    logic emit;

    assign advance    = cmd_valid_reg && (!pixel_valid_reg || !pixel_stall);
    assign cmd_stall  = cmd_valid_reg && !advance;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign is_start   = func_reg == FUNC_START;
    assign emit       = advance && (is_start || active_reg);

    blr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x_start     (x_start_reg),
        .y_start     (y_start_reg),
        .x_end       (x_end_reg),
        .y_end       (y_end_reg),
        .octant      (su_octant),
        .major_pos   (su_major),
        .minor_pos   (su_minor),
        .major_end   (su_end),
        .delta_major (su_dmaj),
        .delta_minor (su_dmin),
        .decision    (su_dec)
    );

    assign cur_octant = is_start ? su_octant : octant_reg;
    assign cur_major  = is_start ? su_major  : major_reg;
    assign cur_minor  = is_start ? su_minor  : minor_reg;
    assign cur_end    = is_start ? su_end    : end_reg;
    assign cur_dmaj   = is_start ? su_dmaj   : dmaj_reg;
    assign cur_dmin   = is_start ? su_dmin   : dmin_reg;
    assign cur_dec    = is_start ? su_dec    : dec_reg;
    assign cur_color  = is_start ? color_reg : held_color_reg;

    blr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .octant        (cur_octant),
        .major_pos     (cur_major),
        .minor_pos     (cur_minor),
        .major_end     (cur_end),
        .delta_major   (cur_dmaj),
        .delta_minor   (cur_dmin),
        .decision      (cur_dec),
        .pixel_x       (st_x),
        .pixel_y       (st_y),
        .last          (st_last),
        .major_next    (st_major),
        .minor_next    (st_minor),
        .decision_next (st_dec)
    );

    always_comb
    begin
        cmd_valid_next   = cmd_valid_reg;
        active_next      = active_reg;
        octant_next      = octant_reg;
        major_next       = major_reg;
        minor_next       = minor_reg;
        end_next         = end_reg;
        dmaj_next        = dmaj_reg;
        dmin_next        = dmin_reg;
        dec_next         = dec_reg;
        held_color_next  = held_color_reg;
        pixel_valid_next = pixel_valid_reg;

        if (cmd_accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_next = 1'b0;
        end

        if (emit)
        begin
            active_next      = !st_last;
            octant_next      = cur_octant;
            major_next       = st_last ? cur_major : st_major;
            minor_next       = st_last ? cur_minor : st_minor;
            end_next         = cur_end;
            dmaj_next        = cur_dmaj;
            dmin_next        = cur_dmin;
            dec_next         = st_last ? cur_dec : st_dec;
            held_color_next  = cur_color;
            pixel_valid_next = 1'b1;
        end
        else if (!pixel_stall)
        begin
            pixel_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg   <= 1'b0;
            active_reg      <= 1'b0;
            octant_reg      <= OCT_SHALLOW_UP;
            major_reg       <= '0;
            minor_reg       <= '0;
            end_reg         <= '0;
            dmaj_reg        <= '0;
            dmin_reg        <= '0;
            dec_reg         <= '0;
            held_color_reg  <= '0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg   <= cmd_valid_next;
            active_reg      <= active_next;
            octant_reg      <= octant_next;
            major_reg       <= major_next;
            minor_reg       <= minor_next;
            end_reg         <= end_next;
            dmaj_reg        <= dmaj_next;
            dmin_reg        <= dmin_next;
            dec_reg         <= dec_next;
            held_color_reg  <= held_color_next;
            pixel_valid_reg <= pixel_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            func_reg    <= func;
            x_start_reg <= x_start;
            y_start_reg <= y_start;
            x_end_reg   <= x_end;
            y_end_reg   <= y_end;
            color_reg   <= line_color;
        end
        if (emit)
        begin
            pixel_x_reg     <= st_x;
            pixel_y_reg     <= st_y;
            pixel_color_reg <= cur_color;
            last_pixel_reg  <= st_last;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

endmodule

>>> rtl/blr_checker.sv
// ----------------------------------------------------------------------------
// blr_checker
// port-level assertions for the line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blr_checker import blr_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_stall,
    input logic                         func,
    input logic signed [COORD_BITS-1:0] x_start,
    input logic signed [COORD_BITS-1:0] y_start,
    input logic signed [COORD_BITS-1:0] x_end,
    input logic signed [COORD_BITS-1:0] y_end,
    input logic [COLOR_BITS-1:0]        line_color,
    input logic                         pixel_valid,
    input logic                         pixel_stall,
    input logic signed [COORD_BITS-1:0] pixel_x,
    input logic signed [COORD_BITS-1:0] pixel_y,
    input logic [COLOR_BITS-1:0]        pixel_color,
    input logic                         last_pixel
);

    logic                                start_accept;
    logic                                single_point;
    logic                                pixel_free;
    logic [2*COORD_BITS+COLOR_BITS:0]    pixel_bus;

    assign start_accept = cmd_valid && !cmd_stall && func == FUNC_START;
    assign single_point = x_start == x_end && y_start == y_end;
    assign pixel_free   = !pixel_valid || !pixel_stall;
    assign pixel_bus    = {pixel_x, pixel_y, pixel_color, last_pixel};

    // start taken and the pixel register free on the next edge
    sequence start_taken;
        start_accept ##1 pixel_free;
    endsequence

    // stalled pixel holds
    `BLR_ASSERT(a_pixel_hold, pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_bus))

    // command backpressure only comes from a stalled pixel
    `BLR_ASSERT(a_stall_cause, cmd_stall |-> pixel_valid && pixel_stall)

    // a start item yields its first pixel with its color once the pixel register is free
    `BLR_ASSERT(a_start_pixel, start_taken |=> pixel_valid && pixel_color == $past(line_color, 2))

    // a single-point line ends on its first pixel
    `BLR_ASSERT(a_single_point, start_accept && single_point ##1 pixel_free |=> last_pixel)

endmodule

bind bresenham_line_rasterizer_unit blr_checker #(
    .COORD_BITS (COORD_BITS)
) u_blr_checker (.*);
